// File: sv/json_scalar_lexer_assert.svh
// Assertion macros used by the lexer's top-level RTL file.
`ifndef JSON_SCALAR_LEXER_ASSERT_SVH
`define JSON_SCALAR_LEXER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JSL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define JSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/jsl_pkg.sv
// Types and codes shared by the JSON scalar lexer modules.
package jsl_pkg;

  // Parse phases.
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_NUM   = 3'd2;
  localparam logic [2:0] PH_STR   = 3'd3;
  localparam logic [2:0] PH_ESC   = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;

  // Verdict status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_EXPECT       = 3'd1;
  localparam logic [2:0] ST_INVALID      = 3'd2;
  localparam logic [2:0] ST_NOT_SINGULAR = 3'd3;
  localparam logic [2:0] ST_BAD_ESC      = 3'd4;
  localparam logic [2:0] ST_BAD_CHAR     = 3'd5;
  localparam logic [2:0] ST_NO_QUOTE     = 3'd6;

  // Value type codes.
  localparam logic [2:0] TY_NULL   = 3'd0;
  localparam logic [2:0] TY_FALSE  = 3'd1;
  localparam logic [2:0] TY_TRUE   = 3'd2;
  localparam logic [2:0] TY_NUMBER = 3'd3;
  localparam logic [2:0] TY_STRING = 3'd4;

  // One input item.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       verdict_valid;
    logic [2:0] status;
    logic [2:0] value_type;
  } out_item_t;

  // Parser state carried from one item to the next.
  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] lit_pos;
    logic [1:0] lit_kind;
    logic [2:0] num_step;
    logic [2:0] found_type;
    logic       failed;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_LEAD,
    lit_pos:    3'd0,
    lit_kind:   2'd0,
    num_step:   3'd0,
    found_type: TY_NULL,
    failed:     1'b0
  };

endpackage

// File: sv/jsl_step.sv
// Next-state and result logic of the lexer for one accepted byte.
module jsl_step (
  input  jsl_pkg::state_t    st,
  input  jsl_pkg::in_item_t  item,
  output jsl_pkg::state_t    st_nxt,
  output logic               res_vld,
  output jsl_pkg::out_item_t res
);
  import jsl_pkg::*;

  localparam logic [3:0] NUM_REJECT = 4'd8;

  // Number grammar: 0 after minus, 1 after leading zero, 2 integer digits,
  // 3 after point, 4 fraction digits, 5 after e, 6 after exponent sign,
  // 7 exponent digits.
  function automatic logic [3:0] num_next(input logic [2:0] s, input logic [7:0] b);
    logic dig;
    logic dot;
    logic expo;
    logic [3:0] n;
    dig  = (b >= 8'h30) && (b <= 8'h39);
    dot  = (b == 8'h2E);
    expo = (b == 8'h65) || (b == 8'h45);
    n    = NUM_REJECT;
    case (s)
      3'd0: n = (b == 8'h30) ? 4'd1 : dig ? 4'd2 : NUM_REJECT;
      3'd1: n = dot ? 4'd3 : expo ? 4'd5 : NUM_REJECT;
      3'd2: n = dig ? 4'd2 : dot ? 4'd3 : expo ? 4'd5 : NUM_REJECT;
      3'd3: n = dig ? 4'd4 : NUM_REJECT;
      3'd4: n = dig ? 4'd4 : expo ? 4'd5 : NUM_REJECT;
      3'd5: n = ((b == 8'h2B) || (b == 8'h2D)) ? 4'd6 : dig ? 4'd7 : NUM_REJECT;
      3'd6: n = dig ? 4'd7 : NUM_REJECT;
      default: n = dig ? 4'd7 : NUM_REJECT;
    endcase
    return n;
  endfunction

  function automatic logic num_terminal(input logic [2:0] s);
    return (s == 3'd1) || (s == 3'd2) || (s == 3'd4) || (s == 3'd7);
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  // Characters of the literals null, false and true; zero past the end.
  function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    unique case (k)
      2'd1: begin
        case (p)
          3'd0: c = 8'h66;
          3'd1: c = 8'h61;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h73;
          3'd4: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          3'd0: c = 8'h74;
          3'd1: c = 8'h72;
          3'd2: c = 8'h75;
          3'd3: c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0: c = 8'h6E;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6C;
          3'd3: c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic out_item_t mk_verdict(input logic [2:0] s, input logic [2:0] t);
    out_item_t r;
    r               = '0;
    r.verdict_valid = 1'b1;
    r.status        = s;
    r.value_type    = (s == ST_OK) ? t : TY_NULL;
    return r;
  endfunction

  function automatic out_item_t mk_data(input logic [7:0] b);
    out_item_t r;
    r            = '0;
    r.data_byte  = b;
    r.data_valid = 1'b1;
    return r;
  endfunction

  logic [7:0] b;
  logic       doc_end;
  logic [3:0] n_step;
  logic [3:0] n_first;
  logic [1:0] k;
  logic [2:0] k_len;
  logic [2:0] pos_inc;

  assign b       = item.text_byte;
  assign doc_end = item.end_of_text || (b == 8'h00);
  assign n_step  = num_next(st.num_step, b);
  assign n_first = num_next(3'd0, b);
  assign k       = (st.lit_kind == 2'd3) ? 2'd0 : st.lit_kind;
  assign k_len   = (k == 2'd1) ? 3'd5 : 3'd4;
  assign pos_inc = st.lit_pos + 3'd1;

  // One step of the parser.
  always_comb begin
    st_nxt  = st;
    res_vld = 1'b0;
    res     = '0;
    if (doc_end) begin
      // End of document: verdict unless one went out already, then rearm.
      st_nxt  = STATE_RESET;
      res_vld = !st.failed;
      unique case (st.phase)
        PH_LIT:   res = mk_verdict(ST_INVALID, TY_NULL);
        PH_NUM:   res = num_terminal(st.num_step) ? mk_verdict(ST_OK, TY_NUMBER)
                                                  : mk_verdict(ST_INVALID, TY_NULL);
        PH_STR:   res = mk_verdict(ST_NO_QUOTE, TY_NULL);
        PH_ESC:   res = mk_verdict(ST_BAD_ESC, TY_NULL);
        PH_TRAIL: res = mk_verdict(ST_OK, st.found_type);
        default:  res = mk_verdict(ST_EXPECT, TY_NULL);
      endcase
    end else if (!st.failed) begin
      unique case (st.phase)
        PH_LIT: begin
          if ((st.lit_pos >= k_len) || (b != lit_char(k, st.lit_pos))) begin
            res_vld = 1'b1;
            res     = mk_verdict(ST_INVALID, TY_NULL);
          end else begin
            st_nxt.lit_pos = pos_inc;
            if (pos_inc == k_len) begin
              st_nxt.found_type = {1'b0, k};
              st_nxt.phase      = PH_TRAIL;
            end
          end
        end
        PH_NUM: begin
          if (n_step != NUM_REJECT) begin
            st_nxt.num_step = n_step[2:0];
            res_vld         = 1'b1;
            res             = mk_data(b);
          end else if (num_terminal(st.num_step)) begin
            // The number ends here; this byte counts as trailing text.
            st_nxt.found_type = TY_NUMBER;
            st_nxt.phase      = PH_TRAIL;
            if (!is_ws(b)) begin
              res_vld = 1'b1;
              res     = mk_verdict(ST_NOT_SINGULAR, TY_NULL);
            end
          end else begin
            res_vld = 1'b1;
            res     = mk_verdict(ST_INVALID, TY_NULL);
          end
        end
        PH_STR: begin
          if (b == 8'h22) begin
            st_nxt.found_type = TY_STRING;
            st_nxt.phase      = PH_TRAIL;
          end else if (b == 8'h5C) begin
            st_nxt.phase = PH_ESC;
          end else if (b < 8'h20) begin
            res_vld = 1'b1;
            res     = mk_verdict(ST_BAD_CHAR, TY_NULL);
          end else begin
            res_vld = 1'b1;
            res     = mk_data(b);
          end
        end
        PH_ESC: begin
          res_vld      = 1'b1;
          st_nxt.phase = PH_STR;
          unique case (b)
            8'h22:   res = mk_data(8'h22);
            8'h5C:   res = mk_data(8'h5C);
            8'h2F:   res = mk_data(8'h2F);
            8'h62:   res = mk_data(8'h08);
            8'h66:   res = mk_data(8'h0C);
            8'h6E:   res = mk_data(8'h0A);
            8'h72:   res = mk_data(8'h0D);
            8'h74:   res = mk_data(8'h09);
            default: begin
              st_nxt.phase = PH_ESC;
              res          = mk_verdict(ST_BAD_ESC, TY_NULL);
            end
          endcase
        end
        PH_TRAIL: begin
          if (!is_ws(b)) begin
            res_vld = 1'b1;
            res     = mk_verdict(ST_NOT_SINGULAR, TY_NULL);
          end
        end
        default: begin
          // Leading whitespace, then the first byte of the value.
          st_nxt.phase = PH_LEAD;
          if (is_ws(b)) begin
            res_vld = 1'b0;
          end else if ((b == 8'h6E) || (b == 8'h66) || (b == 8'h74)) begin
            st_nxt.lit_kind = (b == 8'h6E) ? 2'd0 : (b == 8'h66) ? 2'd1 : 2'd2;
            st_nxt.lit_pos  = 3'd1;
            st_nxt.phase    = PH_LIT;
          end else if (b == 8'h22) begin
            st_nxt.phase = PH_STR;
          end else if (b == 8'h2D) begin
            st_nxt.num_step = 3'd0;
            st_nxt.phase    = PH_NUM;
            res_vld         = 1'b1;
            res             = mk_data(b);
          end else if (n_first == NUM_REJECT) begin
            res_vld = 1'b1;
            res     = mk_verdict(ST_INVALID, TY_NULL);
          end else begin
            st_nxt.num_step = n_first[2:0];
            st_nxt.phase    = PH_NUM;
            res_vld         = 1'b1;
            res             = mk_data(b);
          end
        end
      endcase
      // Any verdict closes the document until the end item.
      if (res_vld && res.verdict_valid) begin
        st_nxt.failed = 1'b1;
      end
    end
  end

endmodule

// File: sv/jsl_outq.sv
// Two-entry output queue that decouples result delivery from byte intake.
module jsl_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jsl_pkg::out_item_t push_item,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output jsl_pkg::out_item_t out_item
);
  import jsl_pkg::*;

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  out_item_t  head_r;
  out_item_t  tail_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_item  = head_r;
  assign pop       = out_valid && out_ready;

  // Occupancy count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage: the head is what the output shows.
  always_ff @(posedge clk) begin
    if (cnt_r == 2'd2) begin
      if (pop) begin
        head_r <= tail_r;
      end
    end else if (cnt_r == 2'd1) begin
      if (push && pop) begin
        head_r <= push_item;
      end else if (push) begin
        tail_r <= push_item;
      end
    end else if (push) begin
      head_r <= push_item;
    end
  end

endmodule

// File: sv/json_scalar_lexer.sv
// Top level of the streaming JSON scalar lexer.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | in_item: text_byte, end_of_text
//  out     | out_valid/out_ready | out_item: data_byte, data_valid,
//          |                     |           verdict_valid, status, value_type
//
// One byte is taken every cycle while in_ready is high; the parser state
// register closes the parser's only loop; each byte's result is written
// into the output queue as the byte is accepted. A two-entry output queue
// holds results; in_ready falls only while both entries wait, and a byte
// that gives no result still needs a free entry. Synchronous active-low
// reset returns the parser to leading whitespace and empties the queue.
module json_scalar_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output jsl_pkg::out_item_t out_item
);
  import jsl_pkg::*;

`include "json_scalar_lexer_assert.svh"

  state_t    state_r;
  state_t    state_nxt;
  logic      res_vld;
  out_item_t res;
  logic      q_full;
  logic      in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // Parser step for the byte on the input.
  jsl_step u_step (
    .st     (state_r),
    .item   (in_item),
    .st_nxt (state_nxt),
    .res_vld(res_vld),
    .res    (res)
  );

  // Parser state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result queue.
  jsl_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire && res_vld),
    .push_item(res),
    .full     (q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // An end item always rearms the parser.
  `JSL_ASSERT_NEXT(a_end_rearms, in_fire && in_item.end_of_text, state_r == STATE_RESET, "end item did not rearm parser")

  // Once a verdict is out, ordinary bytes give no result.
  `JSL_ASSERT_NOW(a_quiet_after_verdict, state_r.failed && !in_item.end_of_text && (in_item.text_byte != 8'h00), !res_vld, "result after verdict")

  // A verdict from an ordinary byte closes the document.
  `JSL_ASSERT_NEXT(a_verdict_closes, in_fire && res_vld && res.verdict_valid && !in_item.end_of_text && (in_item.text_byte != 8'h00), state_r.failed, "verdict did not close document")

  // After a result is queued, the queue shows a valid output in the next cycle.
  `JSL_ASSERT_NEXT(a_result_shown, in_fire && res_vld, out_valid, "queued result not shown")

endmodule
